### rtl/core/hcg_pkg.sv
// Package for the height colour gradient: stop colours, special colours and result classes.
`default_nettype none
package hcg_pkg;

  localparam int HEIGHT_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  localparam logic [23:0] COLOR_WHITE  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_BLUE   = 24'h0000FF;
  localparam logic [23:0] COLOR_GREEN  = 24'h00FF00;
  localparam logic [23:0] COLOR_YELLOW = 24'hFFFF00;
  localparam logic [23:0] COLOR_ORANGE = 24'hFFA500;
  localparam logic [23:0] COLOR_RED    = 24'hFF0000;

  localparam logic [2:0] STOP_BLUE   = 3'd0;
  localparam logic [2:0] STOP_GREEN  = 3'd1;
  localparam logic [2:0] STOP_YELLOW = 3'd2;
  localparam logic [2:0] STOP_ORANGE = 3'd3;
  localparam logic [2:0] STOP_RED    = 3'd4;

  // what the pipeline does with an item
  typedef enum logic [1:0] {
    CLS_BLEND,
    CLS_WHITE,
    CLS_BLUE,
    CLS_RED
  } cls_t;

  function automatic logic [23:0] stop_color(input logic [2:0] idx);
    logic [23:0] c;
    unique case (idx)
      STOP_BLUE:   c = COLOR_BLUE;
      STOP_GREEN:  c = COLOR_GREEN;
      STOP_YELLOW: c = COLOR_YELLOW;
      STOP_ORANGE: c = COLOR_ORANGE;
      STOP_RED:    c = COLOR_RED;
      default:     c = COLOR_RED;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/height_color_gradient.sv
// Top level: pipelined height to RGB colour gradient with APB range registers.
//
//  channel | direction | transfer when                         | payload
//  in_     | slave     | in_tvalid & in_tready                 | height
//  out_    | master    | out_tvalid & out_tready               | rgb_color
//  cfg_    | APB       | cfg_psel & cfg_penable & cfg_pwrite   | height_min @0, height_max @4
//
// One item per cycle sustained while the output is not stalled; the pipeline depth is set by the
// restoring divider that resolves one quotient bit per stage.
// Synchronous active-low reset clears valid bits and the range registers.
// Each stage moves when empty or when the stage after it moves, so bubbles
// collapse under an output stall and nothing is lost or repeated.
`default_nettype none
module height_color_gradient
  import hcg_pkg::*;
#(
  parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  localparam int IN_TW       = ((HEIGHT_WIDTH + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_TW-1:0] in_tdata,    // [HEIGHT_WIDTH-1:0] height
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [23:0]           out_tdata,   // [23:0] rgb_color
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DW  = HEIGHT_WIDTH + 1;   // differences and magnitudes
  localparam int PW  = FRAC_BITS + 8;      // channel delta times fraction
  localparam int NST = FRAC_BITS + 4;      // pipeline depth
  localparam int ST_DIV  = 2;
  localparam int ST_MULT = FRAC_BITS + 2;
  localparam int ST_OUT  = FRAC_BITS + 3;

  // ---------------- configuration ----------------
  logic signed [HEIGHT_WIDTH-1:0] hmin_r, hmax_r;
  logic                           cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmin_r <= '0;
      hmax_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2]) begin
        hmax_r <= cfg_pwdata[HEIGHT_WIDTH-1:0];
      end else begin
        hmin_r <= cfg_pwdata[HEIGHT_WIDTH-1:0];
      end
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'(hmax_r) : 32'(hmin_r);

  // ---------------- flow control ----------------
  logic [NST-1:0] v_r;
  logic [NST:0]   adv;

  assign adv[NST] = out_tready;
  for (genvar k = 0; k < NST; k++) begin : g_adv
    assign adv[k] = !v_r[k] || adv[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = adv[0];
  assign out_tvalid = v_r[ST_OUT];

  // ---------------- stage 0: differences ----------------
  logic signed [DW-1:0] num_r, den_r;
  logic signed [DW-1:0] z_ext, lo_ext, hi_ext;

  assign z_ext  = DW'($signed(in_tdata[HEIGHT_WIDTH-1:0]));
  assign lo_ext = DW'(hmin_r);
  assign hi_ext = DW'(hmax_r);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      num_r <= z_ext - lo_ext;
      den_r <= hi_ext - lo_ext;
    end
  end

  // ---------------- stage 1: magnitudes and class ----------------
  logic [DW-1:0] unum, uden, unum_r, uden_r;
  cls_t          cls, cls_r;

  always_comb begin
    unum = num_r[DW-1] ? DW'(-num_r) : DW'(num_r);
    uden = den_r[DW-1] ? DW'(-den_r) : DW'(den_r);
    priority if (den_r == '0) begin
      cls = CLS_WHITE;
    end else if (num_r != '0 && (num_r[DW-1] != den_r[DW-1])) begin
      cls = CLS_BLUE;    // position below zero
    end else if (unum >= uden) begin
      cls = CLS_RED;     // position at or above one
    end else begin
      cls = CLS_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      unum_r <= unum;
      uden_r <= uden;
      cls_r  <= cls;
    end
  end

  // ---------------- stages 2..: restoring divider, one bit each ----------------
  // remainder starts below the divisor, so the quotient is pure fraction
  logic [DW-1:0]        rem_r [FRAC_BITS];
  logic [DW-1:0]        dsr_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS];
  cls_t                 dcl_r [FRAC_BITS];

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
    logic [DW-1:0]        rem_in, dsr_in;
    logic [FRAC_BITS-1:0] quo_in;
    cls_t                 cls_in;
    logic [DW:0]          shl, dif;
    logic                 ge;

    if (i == 0) begin : g_first
      assign rem_in = unum_r;
      assign dsr_in = uden_r;
      assign quo_in = '0;
      assign cls_in = cls_r;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dsr_in = dsr_r[i-1];
      assign quo_in = quo_r[i-1];
      assign cls_in = dcl_r[i-1];
    end

    assign shl = {rem_in, 1'b0};
    assign dif = shl - {1'b0, dsr_in};
    assign ge  = !dif[DW];

    always_ff @(posedge clk) begin
      if (adv[ST_DIV+i]) begin
        rem_r[i] <= ge ? dif[DW-1:0] : shl[DW-1:0];
        dsr_r[i] <= dsr_in;
        quo_r[i] <= {quo_in[FRAC_BITS-2:0], ge};
        dcl_r[i] <= cls_in;
      end
    end
  end

  // ---------------- segment select and channel products ----------------
  logic [FRAC_BITS-1:0] pos, frac;
  logic [1:0]           seg;
  logic [23:0]          c_lo, c_hi;
  logic [7:0]           ch_lo [3];
  logic [7:0]           ch_hi [3];
  logic [7:0]           ch_d  [3];
  logic                 ch_up [3];
  logic [PW-1:0]        prod_r [3];
  logic [7:0]           base_r [3];
  logic                 up_r   [3];
  cls_t                 mcl_r;

  assign pos  = quo_r[FRAC_BITS-1];
  assign seg  = pos[FRAC_BITS-1 -: 2];
  assign frac = {pos[FRAC_BITS-3:0], 2'b00};
  assign c_lo = stop_color({1'b0, seg});
  assign c_hi = stop_color({1'b0, seg} + 3'd1);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ch_lo[c] = c_lo[8*c +: 8];
      ch_hi[c] = c_hi[8*c +: 8];
      ch_up[c] = ch_hi[c] >= ch_lo[c];
      ch_d[c]  = ch_up[c] ? (ch_hi[c] - ch_lo[c]) : (ch_lo[c] - ch_hi[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MULT]) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= PW'(ch_d[c]) * PW'(frac);
        base_r[c] <= ch_lo[c];
        up_r[c]   <= ch_up[c];
      end
      mcl_r <= dcl_r[FRAC_BITS-1];
    end
  end

  // ---------------- blend and output register ----------------
  logic [PW:0]  rnd   [3];
  logic [23:0]  blend;
  logic [23:0]  color;
  logic [23:0]  out_tdata_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // falling channel rounds the step up so the floor applies to the value
      rnd[c] = {1'b0, prod_r[c]} + {{9{1'b0}}, {FRAC_BITS{1'b1}}};
      blend[8*c +: 8] = up_r[c] ? (base_r[c] + prod_r[c][PW-1:FRAC_BITS])
                                : (base_r[c] - rnd[c][FRAC_BITS+7:FRAC_BITS]);
    end
    unique case (mcl_r)
      CLS_WHITE: color = COLOR_WHITE;
      CLS_BLUE:  color = COLOR_BLUE;
      CLS_RED:   color = COLOR_RED;
      default:   color = blend;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      out_tdata_r <= color;
    end
  end

  assign out_tdata = out_tdata_r;

endmodule
`default_nettype wire

### rtl/core/hcg_checker.sv
// Port-level checker for the height colour gradient, bound to the top level.
`default_nettype none
module hcg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  // a stalled result keeps its colour
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown after reset");

  // an empty or draining output stage never blocks the input
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) |-> in_tready)
    else $error("input blocked with output free");

  // a fresh result never appears straight out of reset
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rst_n))
    else $error("result appeared straight out of reset");

endmodule

bind height_color_gradient hcg_checker u_hcg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### sim/height_color_gradient_test.sv
// Self-checking testbench for the height colour gradient: stream driver, monitor and predictor.
module height_color_gradient_test;
  import hcg_pkg::*;

  localparam int HW        = HEIGHT_WIDTH_DEF;
  localparam int FB        = FRAC_BITS_DEF;
  localparam int LATENCY   = FB + 4;
  localparam int RAND_RUNS = 12;
  localparam int RUN_ITEMS = 95;

  localparam logic [2:0] ADDR_HEIGHT_MIN = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT_MAX = 3'd4;

  localparam logic [23:0] GRADIENT_STOPS [5] = '{
    COLOR_BLUE, COLOR_GREEN, COLOR_YELLOW, COLOR_ORANGE, COLOR_RED
  };

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [HW-1:0] in_tdata = '0;      // [15:0] height
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [23:0]   out_tdata;          // [23:0] rgb_color
  logic          cfg_psel = 1'b0;
  logic          cfg_penable = 1'b0;
  logic          cfg_pwrite = 1'b0;
  logic [2:0]    cfg_paddr = '0;
  logic [31:0]   cfg_pwdata = '0;
  logic [31:0]   cfg_prdata;
  logic          cfg_pready;

  logic [HW-1:0] pending_heights [$];
  logic [23:0]   expected_colors [$];
  logic [HW-1:0] range_lo = '0;
  logic [HW-1:0] range_hi = '0;
  int            send_gap_pct = 0;
  int            recv_stall_pct = 0;
  int            errors = 0;

  height_color_gradient i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  // colour of one height for the given range, Q.FB position, five stops
  function automatic logic [23:0] gradient_color(logic [HW-1:0] z, logic [HW-1:0] lo,
                                                 logic [HW-1:0] hi);
    longint            num;
    longint            den;
    longint unsigned   unum;
    longint unsigned   uden;
    longint unsigned   pos;
    longint unsigned   frac;
    longint unsigned   a;
    longint unsigned   b;
    longint unsigned   mix;
    longint unsigned   one_q;
    int                seg;
    logic [23:0]       c_lo;
    logic [23:0]       c_hi;
    logic [23:0]       rgb;
    num   = longint'($signed(z)) - longint'($signed(lo));
    den   = longint'($signed(hi)) - longint'($signed(lo));
    one_q = 64'd1 << FB;
    if (den == 0) return COLOR_WHITE;
    // opposite signs: position below zero
    if (num != 0 && ((num < 0) != (den < 0))) return COLOR_BLUE;
    unum = (num < 0) ? -num : num;
    uden = (den < 0) ? -den : den;
    pos  = (unum << FB) / uden;
    if (pos >= one_q) return COLOR_RED;
    seg  = int'(pos >> (FB - 2));
    frac = (pos << 2) & (one_q - 1);
    c_lo = GRADIENT_STOPS[seg];
    c_hi = GRADIENT_STOPS[seg + 1];
    for (int k = 0; k < 3; k++) begin
      a = c_lo[8*k +: 8];
      b = c_hi[8*k +: 8];
      // falling channel rounds the step up, so the result floors
      if (b >= a) mix = a + (((b - a) * frac) >> FB);
      else mix = a - (((a - b) * frac + one_q - 1) >> FB);
      rgb[8*k +: 8] = mix[7:0];
    end
    return rgb;
  endfunction

  // driver: one height per transfer, expectation taken at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        expected_colors.push_back(gradient_color(in_tdata, range_lo, range_hi));
      if (!in_tvalid || in_tready) begin
        if (pending_heights.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= pending_heights.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [23:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: rgb_color expected none, actual %06h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_colors.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: rgb_color expected %06h, actual %06h", $time, want, out_tdata);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic set_idle(int mode);
    case (mode)
      0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_gap_pct = 82; recv_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  recv_stall_pct = 82; end
      default: begin send_gap_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  task automatic drain();
    while (pending_heights.size() != 0 || in_tvalid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // write one range register, then read it back
  task automatic write_range_reg(logic [2:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_HEIGHT_MIN) range_lo = data[HW-1:0];
    else if (addr == ADDR_HEIGHT_MAX) range_hi = data[HW-1:0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[HW-1:0] !== data[HW-1:0]) begin
      $display("%0t: register %0d expected %04h, actual %04h", $time, addr,
               data[HW-1:0], cfg_prdata[HW-1:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits are noise the block must drop
  task automatic set_range(logic [HW-1:0] lo, logic [HW-1:0] hi);
    write_range_reg(ADDR_HEIGHT_MIN, {16'($urandom), lo});
    write_range_reg(ADDR_HEIGHT_MAX, {16'($urandom), hi});
  endtask

  initial begin
    int lo_i;
    int hi_i;
    int span_lo;
    int span_hi;
    int swap_tmp;
    int pick;
    int r;
    set_idle(0);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // range registers cleared by reset: empty range, all white
    pending_heights = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001};
    drain();

    // widest range, around the stop boundaries
    set_range(16'h8000, 16'h7FFF);
    pending_heights = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'hC000, 16'hBFFF,
                        16'h3FFF, 16'h4000, 16'h7FFE, 16'h8001};
    drain();

    // inverted range
    set_range(16'h7FFF, 16'h8000);
    pending_heights = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0064};
    drain();

    // narrow range: below, at the ends, above
    set_range(16'hFF9C, 16'h0064);
    pending_heights = '{16'hFF9B, 16'h0065, 16'h0064, 16'hFF9C, 16'h0000};
    drain();

    for (int ph = 0; ph < RAND_RUNS; ph++) begin
      case (ph % 6)
        0: begin lo_i = -32768; hi_i = 32767; end
        1: begin lo_i = 32767;  hi_i = -32768; end
        2: begin
          lo_i = int'($urandom_range(0, 65527)) - 32768;
          hi_i = lo_i + int'($urandom_range(1, 8));
          if ($urandom_range(1)) begin
            swap_tmp = lo_i; lo_i = hi_i; hi_i = swap_tmp;
          end
        end
        3: begin
          lo_i = int'($urandom_range(0, 65535)) - 32768;
          hi_i = int'($urandom_range(0, 65535)) - 32768;
        end
        4: begin
          lo_i = int'($urandom_range(0, 65535)) - 32768;
          hi_i = lo_i;
        end
        default: begin
          lo_i = int'($urandom_range(0, 4000)) - 2000;
          hi_i = lo_i + int'($urandom_range(1, 30000));
        end
      endcase
      set_idle(ph % 4);
      set_range(16'(lo_i), 16'(hi_i));
      span_lo = (lo_i < hi_i) ? lo_i : hi_i;
      span_hi = (lo_i < hi_i) ? hi_i : lo_i;
      for (int n = 0; n < RUN_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 60) pick = span_lo + int'($urandom_range(0, span_hi - span_lo));
        else if (r < 80) pick = int'($urandom_range(0, 65535));
        else pick = (r[0] ? lo_i : hi_i) + int'($urandom_range(0, 4)) - 2;
        pending_heights.push_back(16'(pick));
        // hold the sender back until the pipeline has emptied
        if (n == RUN_ITEMS / 2 && (ph == 3 || ph == 9)) begin
          while (pending_heights.size() != 0) @(posedge clk);
          drain();
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### files.f
rtl/core/hcg_pkg.sv
rtl/core/height_color_gradient.sv
rtl/core/hcg_checker.sv
sim/height_color_gradient_test.sv
